@@ design/assert_macros.svh @@
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define DBA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property that must hold on the cycle after a trigger
`define DBA_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

@@ design/dba_pkg.sv @@
// types and constants of the descriptor bitmap allocator
`timescale 1ns / 1ps

package dba_pkg;

	localparam int NDESC = 8;
	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] IDX_MASK = 3'h7;
	localparam logic [NDESC-1:0] ALL_FREE = 8'hff;
	localparam logic [IDX_W-1:0] WALK_LAST = IDX_MASK;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_LINK  = 2'd2,
		CMD_CHAIN = 2'd3
	} cmd_e_t;

	typedef enum logic [1:0] {
		STAT_OK           = 2'd0,
		STAT_NONE_FREE    = 2'd1,
		STAT_ALREADY_FREE = 2'd2,
		STAT_TOO_LONG     = 2'd3
	} status_e_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WALK = 2'b10
	} state_t;

	typedef struct packed {
		logic             has_next;
		logic [IDX_W-1:0] next_slot;
	} link_t;

	// bitmap changes requested by the control
	typedef struct packed {
		logic             release_en;
		logic [IDX_W-1:0] release_idx;
		logic             claim_en;
		logic [IDX_W-1:0] claim_idx;
	} map_upd_t;

endpackage

@@ design/descriptor_bitmap_allocator.sv @@
// descriptor allocator top level: command control and chain walk
// alloc and free results are registered and appear in the next cycle; set link gives none.
// alloc, free and set link: busy stays low, next command may follow in the next cycle.
// free chain: n results, one per cycle, registered from the walk steps that follow the head
// link read, one link-store read per step; busy during the walk, next command taken in idle.
// reset: every descriptor free, all links cleared through valid bits; no clearing pass.
// the receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module descriptor_bitmap_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                cmd,
	input  logic [dba_pkg::IDX_W-1:0] slot,
	input  logic [dba_pkg::IDX_W-1:0] link_target,
	input  logic                      link_valid,
	output logic                      strobe,
	output logic [dba_pkg::IDX_W-1:0] slot_out,
	output logic [1:0]                status,
	output logic                      last
);
	import dba_pkg::*;

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  cur_q, cur_d;
	logic [IDX_W-1:0]  cnt_q, cnt_d;
	logic              strobe_q, strobe_d;
	logic [IDX_W-1:0]  slot_out_q, slot_out_d;
	status_e_t         status_q, status_d;
	logic              last_q, last_d;

	map_upd_t          upd;
	logic [NDESC-1:0]  map;
	logic              any_free;
	logic [IDX_W-1:0]  first_free;

	logic              mem_wr_en;
	link_t             mem_wr_data;
	logic [IDX_W-1:0]  mem_rd_addr;
	link_t             link_rd;
	logic              accept;

	dba_free_map u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.map        (map),
		.any_free   (any_free),
		.first_free (first_free)
	);

	dba_link_mem u_links (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (mem_wr_en),
		.wr_addr  (slot),
		.wr_data  (mem_wr_data),
		.clr_en   (upd.release_en),
		.clr_addr (upd.release_idx),
		.rd_addr  (mem_rd_addr),
		.rd_data  (link_rd)
	);

	assign accept                = start && (state_q == S_IDLE);
	assign mem_wr_data.has_next  = link_valid;
	assign mem_wr_data.next_slot = link_target;

	always_comb begin
		state_d     = state_q;
		cur_d       = cur_q;
		cnt_d       = cnt_q;
		strobe_d    = 1'b0;
		slot_out_d  = slot_out_q;
		status_d    = status_q;
		last_d      = last_q;
		upd         = '0;
		mem_wr_en   = 1'b0;
		mem_rd_addr = slot;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd_e_t'(cmd))
						CMD_ALLOC: begin
							strobe_d = 1'b1;
							last_d   = 1'b1;
							if (any_free) begin
								upd.claim_en  = 1'b1;
								upd.claim_idx = first_free;
								slot_out_d    = first_free;
								status_d      = STAT_OK;
							end else begin
								slot_out_d = '0;
								status_d   = STAT_NONE_FREE;
							end
						end
						CMD_FREE: begin
							strobe_d   = 1'b1;
							last_d     = 1'b1;
							slot_out_d = slot;
							if (map[slot]) begin
								status_d = STAT_ALREADY_FREE;
							end else begin
								upd.release_en  = 1'b1;
								upd.release_idx = slot;
								status_d        = STAT_OK;
							end
						end
						CMD_LINK: begin
							mem_wr_en = 1'b1;
						end
						CMD_CHAIN: begin
							// link of the head is read now, used next cycle
							cur_d   = slot;
							cnt_d   = '0;
							state_d = S_WALK;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_WALK: begin
				strobe_d    = 1'b1;
				slot_out_d  = cur_q;
				mem_rd_addr = link_rd.next_slot;
				if (map[cur_q]) begin
					status_d = STAT_ALREADY_FREE;
					last_d   = 1'b1;
					state_d  = S_IDLE;
				end else begin
					upd.release_en  = 1'b1;
					upd.release_idx = cur_q;
					if (!link_rd.has_next) begin
						status_d = STAT_OK;
						last_d   = 1'b1;
						state_d  = S_IDLE;
					end else if (cnt_q == WALK_LAST) begin
						status_d = STAT_TOO_LONG;
						last_d   = 1'b1;
						state_d  = S_IDLE;
					end else begin
						status_d = STAT_OK;
						last_d   = 1'b0;
						cur_d    = link_rd.next_slot;
						cnt_d    = cnt_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
			cur_q    <= '0;
			cnt_q    <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
			cur_q    <= cur_d;
			cnt_q    <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_out_q <= slot_out_d;
		status_q   <= status_d;
		last_q     <= last_d;
	end

	assign busy     = (state_q == S_WALK);
	assign strobe   = strobe_q;
	assign slot_out = slot_out_q;
	assign status   = status_q;
	assign last     = last_q;

	// a non-final chain transfer always leaves the walk running
	`DBA_ASSERT(a_mid_chain_busy, clk, arst_n, !(strobe && !last) || busy,
		"chain result without last while walk stopped")
	// set link produces no transfer
	`DBA_ASSERT_NEXT(a_link_silent, clk, arst_n,
		start && !busy && (cmd == CMD_LINK), !strobe, "set link produced a result")
	// alloc and free give exactly one final transfer in the next cycle
	`DBA_ASSERT_NEXT(a_single_result, clk, arst_n,
		start && !busy && ((cmd == CMD_ALLOC) || (cmd == CMD_FREE)),
		strobe && last && !busy, "single command did not give one final result")
	// none free always reports descriptor zero
	`DBA_ASSERT(a_none_free_zero, clk, arst_n,
		!(strobe && (status == STAT_NONE_FREE)) || (slot_out == '0),
		"none free with nonzero descriptor")

endmodule

@@ design/dba_link_mem.sv @@
// chain link store: synchronous memory with per-entry valid bits
`timescale 1ns / 1ps

module dba_link_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [dba_pkg::IDX_W-1:0] wr_addr,
	input  dba_pkg::link_t            wr_data,
	input  logic                      clr_en,
	input  logic [dba_pkg::IDX_W-1:0] clr_addr,
	input  logic [dba_pkg::IDX_W-1:0] rd_addr,
	output dba_pkg::link_t            rd_data
);
	import dba_pkg::*;

	link_t             mem [NDESC];
	link_t             rd_data_q;
	logic [IDX_W-1:0]  rd_addr_q;
	logic [NDESC-1:0]  valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
		rd_addr_q <= rd_addr;
	end

	// a cleared link is modeled by dropping the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end else if (clr_en) begin
			valid_q[clr_addr] <= 1'b0;
		end
	end

	assign rd_data = valid_q[rd_addr_q] ? rd_data_q : '0;

endmodule

@@ design/dba_free_map.sv @@
// free bitmap with lowest-free search
`timescale 1ns / 1ps

module dba_free_map (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dba_pkg::map_upd_t         upd,
	output logic [dba_pkg::NDESC-1:0] map,
	output logic                      any_free,
	output logic [dba_pkg::IDX_W-1:0] first_free
);
	import dba_pkg::*;

	logic [NDESC-1:0] map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= ALL_FREE;
		end else begin
			if (upd.release_en) begin
				map_q[upd.release_idx] <= 1'b1;
			end
			if (upd.claim_en) begin
				map_q[upd.claim_idx] <= 1'b0;
			end
		end
	end

	// scan downward so the lowest free index wins
	always_comb begin
		first_free = '0;
		for (int i = NDESC - 1; i >= 0; i--) begin
			if (map_q[i]) begin
				first_free = IDX_W'(i);
			end
		end
	end

	assign any_free = |map_q;
	assign map      = map_q;

endmodule
